>>> rtl/core/lrpc_pkg.sv
// Package for the log record parser: header layout, length masks and CRC-32 byte update.
`timescale 1ns / 1ps
`default_nettype none

package lrpc_pkg;

  // Captured length widths (header layout stays fixed)
  localparam int KEY_LEN_BITS   = 16;
  localparam int VALUE_LEN_BITS = 32;

  localparam logic [15:0] KEY_LEN_MASK   = 16'((64'd1 << KEY_LEN_BITS) - 64'd1);
  localparam logic [31:0] VALUE_LEN_MASK = 32'((64'd1 << VALUE_LEN_BITS) - 64'd1);

  // Header byte offsets
  localparam int TYPE_POS  = 4;
  localparam int TIME_POS  = 5;
  localparam int SEQ_POS   = 13;
  localparam int KLEN_POS  = 21;
  localparam int VLEN_POS  = 23;
  localparam int HDR_SIZE  = 27;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Record status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_CRC_ERROR = 2'd2
  } status_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/log_record_parse_crc_check.sv
// Top level: length-prefixed log record parser with CRC-32 check.
//
//  channel   dir  handshake                tdata / tuser / tlast
//  s_axis    in   s_axis_tvalid/tready     stream_byte / - / buffer_end
//  m_axis    out  m_axis_tvalid/tready     header fields+status / flags / record_done
//
// One input byte per cycle while the output register is free or taken: the CRC-32
// byte update, header capture and the record length compare sit between the parser
// state and one output register, which loads the result at the accepting edge.
// A byte that neither passes payload nor ends a record gives no output transaction.
// The input is stalled only while the output register is full and not taken.
// Synchronous reset clears the parser state and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module log_record_parse_crc_check
  import lrpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
  input  wire logic         s_axis_tlast,   // buffer_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] payload_byte, [9:8] status, [17:10] record_type, [81:18] timestamp,
  // [145:82] sequence_res, [161:146] key_length, [193:162] value_length,
  // [225:194] stored_crc, [231:226] zero
  output logic [231:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [0] payload_valid, [1] in_value
  output logic              m_axis_tlast    // record_done
);

  // Parser state
  logic [32:0] byte_pos;
  logic [31:0] crc_field_reg;
  logic [7:0]  type_reg;
  logic [63:0] time_reg;
  logic [63:0] seq_reg;
  logic [15:0] key_len_reg;
  logic [31:0] value_len_reg;
  logic [31:0] crc_accum;

  // Values after this byte
  logic [31:0] crc_field_next;
  logic [7:0]  type_next;
  logic [63:0] time_next;
  logic [63:0] seq_next;
  logic [15:0] key_len_next;
  logic [31:0] value_len_next;
  logic [31:0] crc_next;

  logic [4:0]  hdr_pos;
  logic [4:0]  hdr_off;
  logic [15:0] key_used;
  logic [31:0] value_used;
  logic [33:0] rec_len;
  logic        is_payload;
  logic        is_value;
  logic        done_full;
  logic        done;
  status_t     status;
  logic        accept;
  logic        has_result;
  logic [231:0] out_data_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Capture header bytes and advance the CRC
  always_comb begin
    crc_field_next = crc_field_reg;
    type_next      = type_reg;
    time_next      = time_reg;
    seq_next       = seq_reg;
    key_len_next   = key_len_reg;
    value_len_next = value_len_reg;
    hdr_pos        = byte_pos[4:0];
    hdr_off        = 5'd0;
    if (byte_pos < 33'(TYPE_POS)) begin
      crc_field_next[8*hdr_pos[1:0] +: 8] = s_axis_tdata;
    end else if (byte_pos == 33'(TYPE_POS)) begin
      type_next = s_axis_tdata;
    end else if (byte_pos < 33'(SEQ_POS)) begin
      hdr_off = hdr_pos - 5'(TIME_POS);
      time_next[8*hdr_off[2:0] +: 8] = s_axis_tdata;
    end else if (byte_pos < 33'(KLEN_POS)) begin
      hdr_off = hdr_pos - 5'(SEQ_POS);
      seq_next[8*hdr_off[2:0] +: 8] = s_axis_tdata;
    end else if (byte_pos < 33'(VLEN_POS)) begin
      hdr_off = hdr_pos - 5'(KLEN_POS);
      key_len_next[8*hdr_off[0] +: 8] = s_axis_tdata;
    end else if (byte_pos < 33'(HDR_SIZE)) begin
      hdr_off = hdr_pos - 5'(VLEN_POS);
      value_len_next[8*hdr_off[1:0] +: 8] = s_axis_tdata;
    end
    crc_next = (byte_pos >= 33'(TYPE_POS)) ? crc32_byte(crc_accum, s_axis_tdata) : crc_accum;
  end

  // Decide payload section and record end
  always_comb begin
    key_used   = key_len_next & KEY_LEN_MASK;
    value_used = value_len_next & VALUE_LEN_MASK;
    rec_len    = 34'(HDR_SIZE) + {18'd0, key_used} + {2'd0, value_used};
    is_payload = byte_pos >= 33'(HDR_SIZE);
    is_value   = is_payload && (byte_pos >= 33'(HDR_SIZE) + {17'd0, key_used});
    done_full  = (byte_pos >= 33'(HDR_SIZE - 1)) && ({1'b0, byte_pos} + 34'd1 >= rec_len);
    done       = done_full || s_axis_tlast;
    if (done_full) begin
      status = ((crc_next ^ CRC_INIT) == crc_field_next) ? STATUS_OK : STATUS_CRC_ERROR;
    end else begin
      status = STATUS_SHORT;
    end
    has_result = is_payload || done;
  end

  // Assemble the output data; zero fields that do not apply
  always_comb begin
    out_data_next = '0;
    if (is_payload) begin
      out_data_next[7:0] = s_axis_tdata;
    end
    if (done) begin
      out_data_next[9:8]     = status;
      out_data_next[17:10]   = type_next;
      out_data_next[81:18]   = time_next;
      out_data_next[145:82]  = seq_next;
      out_data_next[161:146] = key_used;
      out_data_next[193:162] = value_used;
      out_data_next[225:194] = crc_field_next;
    end
  end

  // Update parser state; restart after any verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      crc_field_reg <= '0;
      type_reg      <= '0;
      time_reg      <= '0;
      seq_reg       <= '0;
      key_len_reg   <= '0;
      value_len_reg <= '0;
      crc_accum     <= CRC_INIT;
    end else if (accept) begin
      if (done) begin
        byte_pos      <= '0;
        crc_field_reg <= '0;
        type_reg      <= '0;
        time_reg      <= '0;
        seq_reg       <= '0;
        key_len_reg   <= '0;
        value_len_reg <= '0;
        crc_accum     <= CRC_INIT;
      end else begin
        byte_pos      <= byte_pos + 33'd1;
        crc_field_reg <= crc_field_next;
        type_reg      <= type_next;
        time_reg      <= time_next;
        seq_reg       <= seq_next;
        key_len_reg   <= key_len_next;
        value_len_reg <= value_len_next;
        crc_accum     <= crc_next;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= accept && has_result;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      m_axis_tuser <= {is_value, is_payload};
      m_axis_tlast <= done;
      m_axis_tdata <= out_data_next;
    end
  end

  // CRC stays at its initial value until the first covered byte
  a_crc_init: assert property (@(posedge clk) disable iff (rst)
    (byte_pos <= 33'(TYPE_POS)) |-> (crc_accum == CRC_INIT))
    else $error("CRC accumulator moved during the CRC field");

  // A verdict restarts the record
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> (byte_pos == 33'd0))
    else $error("byte position not cleared after record end");

  // Every output transaction carries payload or a verdict
  a_no_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
    else $error("empty output transaction");

  // Value flag only on payload bytes
  a_value_flag: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tuser[1] == 1'b0))
    else $error("in_value set without payload");

  // Status is zero unless the record ends
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[9:8] == 2'd0))
    else $error("status set without record end");

endmodule

`default_nettype wire

>>> verif/lrpc_tb_pkg.sv
// Shared verification helpers for the log record parser: bitwise CRC-32 byte step.
`timescale 1ns / 1ps

package lrpc_tb_pkg;
  import lrpc_pkg::CRC_POLY;

  // Reflected CRC-32, one byte, data bits folded in one at a time
  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ b[k]}});
    end
    return r;
  endfunction

endpackage

>>> verif/record_check.sv
// Checker for the log record parser: tracks accepted bytes, predicts and compares results.
`timescale 1ns / 1ps

module record_check
  import lrpc_pkg::*;
  import lrpc_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [231:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic        pay;
    logic        in_val;
    logic [7:0]  pbyte;
    logic        done;
    status_t     st;
    logic [7:0]  rtype;
    logic [63:0] tstamp;
    logic [63:0] seq;
    logic [15:0] klen;
    logic [31:0] vlen;
    logic [31:0] crc;
  } record_result_t;

  // Parser state as seen from the byte stream
  logic [32:0] pos;
  logic [31:0] crc_field;
  logic [7:0]  rtype;
  logic [63:0] tstamp;
  logic [63:0] seq;
  logic [15:0] klen;
  logic [31:0] vlen;
  logic [31:0] crc_acc;

  record_result_t record_results[$];
  record_result_t want;
  int mismatches = 0;
  int waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic clear_record();
    pos       = '0;
    crc_field = '0;
    rtype     = '0;
    tstamp    = '0;
    seq       = '0;
    klen      = '0;
    vlen      = '0;
    crc_acc   = CRC_INIT;
  endtask

  // Advance the record by one byte and queue the result it causes, if any
  task automatic advance_record(input logic [7:0] b, input logic end_mark);
    record_result_t r;
    logic [32:0] p;
    logic [33:0] rec_end;
    int idx;
    r = '0;
    p = pos;
    if (p < 33'(HDR_SIZE)) begin
      idx = int'(p[4:0]);
      if (idx < TYPE_POS) crc_field[idx*8 +: 8] = b;
      else if (idx == TYPE_POS) rtype = b;
      else if (idx < SEQ_POS) tstamp[(idx-TIME_POS)*8 +: 8] = b;
      else if (idx < KLEN_POS) seq[(idx-SEQ_POS)*8 +: 8] = b;
      else if (idx < VLEN_POS) klen[(idx-KLEN_POS)*8 +: 8] = b;
      else vlen[(idx-VLEN_POS)*8 +: 8] = b;
    end else begin
      r.pay    = 1'b1;
      r.pbyte  = b;
      r.in_val = (p - 33'(HDR_SIZE)) >= 33'(klen & KEY_LEN_MASK);
    end
    if (p >= 33'(TYPE_POS)) crc_acc = crc32_next(crc_acc, b);

    // Length reached decides on the CRC; an earlier end mark cuts the record short
    rec_end = 34'(HDR_SIZE) + 34'(klen & KEY_LEN_MASK) + 34'(vlen & VALUE_LEN_MASK);
    if (p >= 33'(HDR_SIZE - 1) && 34'(p) + 34'd1 >= rec_end) begin
      r.done = 1'b1;
      r.st   = (~crc_acc == crc_field) ? STATUS_OK : STATUS_CRC_ERROR;
    end else if (end_mark) begin
      r.done = 1'b1;
      r.st   = STATUS_SHORT;
    end

    if (r.done) begin
      r.rtype  = rtype;
      r.tstamp = tstamp;
      r.seq    = seq;
      r.klen   = klen & KEY_LEN_MASK;
      r.vlen   = vlen & VALUE_LEN_MASK;
      r.crc    = crc_field;
      clear_record();
    end else begin
      pos = p + 33'd1;
    end
    if (r.pay || r.done) record_results = {record_results, r};
  endtask

  task automatic check_field(input string fname, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Compare outputs before predicting, so a same-edge input never matches itself
  always @(posedge clk) begin
    if (rst) begin
      clear_record();
      record_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (record_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual tdata %0h tuser %0h tlast %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = record_results.pop_front();
          check_field("payload_valid", 64'(want.pay), 64'(m_tuser[0]));
          check_field("in_value", 64'(want.in_val), 64'(m_tuser[1]));
          check_field("payload_byte", 64'(want.pbyte), 64'(m_tdata[7:0]));
          check_field("record_done", 64'(want.done), 64'(m_tlast));
          check_field("status", 64'(want.st), 64'(m_tdata[9:8]));
          check_field("record_type", 64'(want.rtype), 64'(m_tdata[17:10]));
          check_field("timestamp", want.tstamp, m_tdata[81:18]);
          check_field("sequence", want.seq, m_tdata[145:82]);
          check_field("key_length", 64'(want.klen), 64'(m_tdata[161:146]));
          check_field("value_length", 64'(want.vlen), 64'(m_tdata[193:162]));
          check_field("stored_crc", 64'(want.crc), 64'(m_tdata[225:194]));
          check_field("pad", 64'd0, 64'(m_tdata[231:226]));
        end
      end
      if (s_tvalid && s_tready) advance_record(s_tdata, s_tlast);
    end
    waiting = record_results.size();
  end

endmodule

>>> verif/tb_log_record_parse_crc_check.sv
// Testbench top for the log record parser: record stimulus, ready pressure and verdict.
`timescale 1ns / 1ps

module tb_log_record_parse_crc_check;
  import lrpc_pkg::*;
  import lrpc_tb_pkg::*;

  localparam int RANDOM_BYTES = 1490;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} hdr_fill_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [231:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int fail_count;
  int pending;
  int tx_idle_pct = 30;
  int rx_idle_pct = 50;
  bit hold_off_req = 1'b0;
  int bytes_sent = 0;
  int stall_cycles = 0;
  logic [7:0] rec_bytes[$];

  log_record_parse_crc_check dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  record_check chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tlast    (s_axis_tlast),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tuser    (m_axis_tuser),
    .m_tlast    (m_axis_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold the input for one transaction, idling first at the current rate
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Lay out one record: header, then body_len bytes, with a true or corrupted CRC
  task automatic build_record(input logic [15:0] klen_f, input logic [31:0] vlen_f,
                              input int body_len, input hdr_fill_t fill, input bit bad_crc);
    logic [31:0] crc;
    logic [7:0] b;
    rec_bytes.delete();
    repeat (TYPE_POS) rec_bytes = {rec_bytes, 8'h00};
    for (int i = TYPE_POS; i < KLEN_POS; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      rec_bytes = {rec_bytes, b};
    end
    for (int i = 0; i < 2; i++) rec_bytes = {rec_bytes, klen_f[i*8 +: 8]};
    for (int i = 0; i < 4; i++) rec_bytes = {rec_bytes, vlen_f[i*8 +: 8]};
    repeat (body_len) rec_bytes = {rec_bytes, 8'($urandom)};
    crc = CRC_INIT;
    for (int i = TYPE_POS; i < rec_bytes.size(); i++) crc = crc32_next(crc, rec_bytes[i]);
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'($urandom) | 32'h1);
    for (int i = 0; i < 4; i++) rec_bytes[i] = crc[i*8 +: 8];
  endtask

  // Send the first count bytes; mark the last one as buffer end if asked
  task automatic send_record(input int count, input bit end_last);
    for (int i = 0; i < count; i++) send_byte(rec_bytes[i], end_last && (i == count - 1));
  endtask

  task automatic send_good(input int kl, input int vl, input hdr_fill_t fill,
                           input bit bad, input bit end_last);
    build_record(16'(kl), 32'(vl), kl + vl, fill, bad);
    send_record(rec_bytes.size(), end_last);
  endtask

  // Ready side: random idling, plus one long hold-off to back up the block
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int kl;
    int vl;
    int total;
    int kind;
    int n;
    int rand_start;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty records, each section, bad CRC, end marks in the CRC field, timestamp, key, value and last byte
    send_good(0, 0, FILL_ZERO, 1'b0, 1'b0);
    send_good(0, 0, FILL_ONES, 1'b0, 1'b1);
    send_good(3, 5, FILL_RANDOM, 1'b0, 1'b0);
    send_good(4, 0, FILL_ONES, 1'b1, 1'b0);
    send_good(0, 6, FILL_ZERO, 1'b0, 1'b1);
    send_good(2, 2, FILL_RANDOM, 1'b1, 1'b1);
    build_record(16'd2, 32'd3, 5, FILL_RANDOM, 1'b0);
    send_record(10, 1'b1);
    send_record(1, 1'b1);
    build_record(16'd5, 32'd5, 10, FILL_ONES, 1'b0);
    send_record(30, 1'b1);
    build_record(16'd2, 32'd6, 8, FILL_ZERO, 1'b0);
    send_record(32, 1'b1);
    build_record(16'hFFFF, 32'hFFFF_FFFF, 8, FILL_ONES, 1'b0);
    send_record(35, 1'b1);
    build_record(16'hFFFF, 32'd0, 4, FILL_RANDOM, 1'b0);
    send_record(29, 1'b1);
    build_record(16'd0, 32'hFFFF_FFFF, 13, FILL_RANDOM, 1'b0);
    send_record(40, 1'b1);

    // Random: mostly well-formed records, some truncated, some raw noise
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if (bytes_sent - rand_start >= 2 * RANDOM_BYTES / 3) begin
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end else if (bytes_sent - rand_start >= RANDOM_BYTES / 3) begin
        tx_idle_pct = 50;
        rx_idle_pct = 30;
      end
      kind = $urandom_range(99);
      kl = $urandom_range(10);
      vl = $urandom_range(16);
      if (kind < 65) begin
        send_good(kl, vl, FILL_RANDOM, 1'b0, 1'($urandom));
      end else if (kind < 80) begin
        send_good(kl, vl, FILL_RANDOM, 1'b1, 1'($urandom));
      end else if (kind < 92) begin
        build_record(16'(kl), 32'(vl), kl + vl, FILL_RANDOM, 1'($urandom));
        total = rec_bytes.size();
        send_record($urandom_range(1, total - 1), 1'b1);
      end else begin
        n = $urandom_range(1, 40);
        rec_bytes.delete();
        repeat (n) rec_bytes = {rec_bytes, 8'($urandom)};
        send_record(n, 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // Drain: wait for every expected result, then a few quiet cycles
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lrpc_pkg.sv
rtl/core/log_record_parse_crc_check.sv
verif/lrpc_tb_pkg.sv
verif/record_check.sv
verif/tb_log_record_parse_crc_check.sv
